// ----- hdl/llms_pkg.sv -----
// ----------------------------------------------------------------------------
// llms_pkg
// Shared types and codes for the least-loaded multi-stack unit.
// ----------------------------------------------------------------------------
package llms_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  typedef struct packed {
    logic               op;
    logic signed [31:0] item_code;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] stack_used;
  } rsp_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch the request, restart the scan
    logic issue;   // read one slot and advance the scan
    logic commit;  // update the store and register the response
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;  // the slot being issued is the final one
  } sts_t;

endpackage

// ----- hdl/llms_ram.sv -----
// ----------------------------------------------------------------------------
// llms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module llms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/llms_datapath.sv -----
// ----------------------------------------------------------------------------
// llms_datapath
// Slot scan, duplicate / top-of-stack compare, least-fill search, fill
// counters, code store and response register.
// ----------------------------------------------------------------------------
module llms_datapath #(
  parameter int NUM_STACKS  = 4,
  parameter int STACK_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  llms_pkg::req_t req_data,
  input  llms_pkg::cmd_t cmd,
  output llms_pkg::sts_t sts,
  output llms_pkg::rsp_t rsp_data
);
  import llms_pkg::*;

  localparam int SLOTS = NUM_STACKS * STACK_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int KW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FW    = $clog2(STACK_DEPTH + 1);

  localparam logic [SW-1:0] LAST_S  = SW'(NUM_STACKS - 1);
  localparam logic [KW-1:0] LAST_K  = KW'(STACK_DEPTH - 1);
  localparam logic [FW-1:0] FULL_F  = FW'(STACK_DEPTH);
  localparam logic [AW-1:0] STEP_AD = AW'(STACK_DEPTH);

  logic [FW-1:0] fill [NUM_STACKS];

  // request held for the whole operation
  logic          op;
  logic [31:0]   code;

  // scan position
  logic [SW-1:0] scan_s;
  logic [KW-1:0] scan_k;
  logic [AW-1:0] base;

  // compare stage
  logic          cmp_valid;
  logic [SW-1:0] cmp_s;
  logic [FW-1:0] cmp_fill;

  // results of the scan
  logic          hit;
  logic [SW-1:0] hit_s;
  logic [FW-1:0] hit_fill;
  logic [SW-1:0] best;
  logic [FW-1:0] best_fill;
  logic [AW-1:0] best_base;

  logic [FW-1:0] fill_s;
  logic          slot_valid;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr;
  rsp_t          rsp_next;

  assign fill_s = fill[scan_s];

  always_comb begin
    if (op == OP_POP) begin
      slot_valid = (fill_s != '0);
      raddr      = base + AW'(fill_s - 1'b1);
    end else begin
      slot_valid = (FW'(scan_k) < fill_s);
      raddr      = base + AW'(scan_k);
    end
  end

  assign sts.scan_last = (scan_s == LAST_S) && ((op == OP_POP) || (scan_k == LAST_K));

  // commit decision
  always_comb begin
    we       = 1'b0;
    waddr    = best_base + AW'(best_fill);
    rsp_next = '{status: ST_OK, stack_used: '0};
    if (op == OP_PUSH) begin
      if (hit) begin
        rsp_next.status = ST_DUP;
      end else if (best_fill >= FULL_F) begin
        rsp_next.status = ST_FULL;
      end else begin
        we                  = cmd.commit;
        rsp_next.stack_used = 4'(best);
      end
    end else begin
      if (hit) begin
        rsp_next.stack_used = 4'(hit_s);
      end else begin
        rsp_next.status = ST_MISS;
      end
    end
  end

  llms_ram #(
    .WIDTH (32),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (code),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill[i] <= '0;
      end
      cmp_valid <= 1'b0;
      hit       <= 1'b0;
    end else begin
      cmp_valid <= cmd.issue && slot_valid;

      if (cmd.load) begin
        op     <= req_data.op;
        code   <= req_data.item_code;
        scan_s <= '0;
        scan_k <= '0;
        base   <= '0;
        hit    <= 1'b0;
      end

      if (cmd.issue) begin
        cmp_s    <= scan_s;
        cmp_fill <= fill_s;
        // least-filled stack, lowest index wins ties
        if (scan_k == '0) begin
          if (scan_s == '0 || fill_s < best_fill) begin
            best      <= scan_s;
            best_fill <= fill_s;
            best_base <= base;
          end
        end
        if (!sts.scan_last) begin
          if (op == OP_POP || scan_k == LAST_K) begin
            scan_k <= '0;
            scan_s <= scan_s + 1'b1;
            base   <= base + STEP_AD;
          end else begin
            scan_k <= scan_k + 1'b1;
          end
        end
      end

      // keep the first match only
      if (cmp_valid && rdata == code && !hit) begin
        hit      <= 1'b1;
        hit_s    <= cmp_s;
        hit_fill <= cmp_fill;
      end

      if (cmd.commit) begin
        rsp_data <= rsp_next;
        if (op == OP_PUSH && !hit && best_fill < FULL_F) begin
          fill[best] <= best_fill + 1'b1;
        end else if (op == OP_POP && hit) begin
          fill[hit_s] <= hit_fill - 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/llms_ctrl.sv -----
// ----------------------------------------------------------------------------
// llms_ctrl
// Sequencer for one operation: accept, scan, drain, commit.
// ----------------------------------------------------------------------------
module llms_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output llms_pkg::cmd_t cmd,
  input  llms_pkg::sts_t sts
);
  import llms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/least_loaded_multi_stack_unit.sv -----
// ----------------------------------------------------------------------------
// least_loaded_multi_stack_unit
// Bounded stacks of item codes: push to the least-filled stack after a
// duplicate check, pop only from a stack top.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   -------   ---------   ---------------------   ------------------------
//   request   in          req_valid / req_stall   req_data  (op, item_code)
//   response  out         rsp_valid / rsp_stall   rsp_data  (status, stack_used)
//
// One request at a time. A push walks every slot of the code store, one RAM
// read a cycle; a pop reads one top per stack. The single read port of the
// code store sets the pace of both. Reset clears the fill counters at once;
// the code store needs no clearing. A stalled response holds in its register
// while the next request is taken; the commit step waits only while that
// register still holds a stalled response.
//
module least_loaded_multi_stack_unit #(
  parameter int NUM_STACKS  = 4,
  parameter int STACK_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  llms_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output llms_pkg::rsp_t rsp_data
);
  import llms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the operation: load, one issue per slot scanned, drain the read, commit.
  llms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold the stacks, compare each read slot against the code, track the
  // least-filled stack and register the response.
  llms_datapath #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_data (rsp_data)
  );

endmodule

// ----- hdl/llms_checker.sv -----
// ----------------------------------------------------------------------------
// llms_checker
// Port-level checks for the least-loaded multi-stack unit, bound to the top.
// ----------------------------------------------------------------------------
module llms_checker #(
  parameter int NUM_STACKS = 4
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input llms_pkg::rsp_t rsp_data
);
  import llms_pkg::*;

  // one request at a time: busy straight after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while a previous one is in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
    else $error("stalled response dropped or changed");

  a_used_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.stack_used == 4'd0))
    else $error("stack index given on a failed request");

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status == ST_OK) |->
      ({1'b0, rsp_data.stack_used} < 5'(NUM_STACKS)))
    else $error("stack index out of range");

endmodule

bind least_loaded_multi_stack_unit llms_checker #(
  .NUM_STACKS (NUM_STACKS)
) u_llms_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);
